// ===== design/llwq_pkg.sv =====
package llwq_pkg;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] queue_sel;
    logic [2:0] dest_queue;
    logic [5:0] waiter_id;
    logic       cursor_valid;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] waiter_out;
    logic       waiter_valid;
    logic [6:0] length_out;
  } rsp_t;

  localparam logic [2:0] KIND_ENQ  = 3'd0;
  localparam logic [2:0] KIND_DEQ  = 3'd1;
  localparam logic [2:0] KIND_XFER = 3'd2;
  localparam logic [2:0] KIND_PEEK = 3'd3;
  localparam logic [2:0] KIND_NEXT = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RQ,
    S_RT,
    S_RH,
    S_RD,
    S_RT2,
    S_W2
  } state_t;

endpackage

// ===== design/linked_list_wait_queues_top.sv =====
// Wait-queue manager: NUM_QUEUES FIFO queues of waiters 0..NUM_WAITERS-1 kept as circular
// lists through their tails in one shared link memory (one read and one write port,
// registered read); per-queue tail and length sit in a second small memory next to a
// flip-flop valid bit per queue. Operations run one at a time through a sequencer whose
// steps are the dependent link-memory reads. A rejected transaction, an enqueue onto an
// empty queue and a dequeue, peek or next-after on an empty queue finish on the queue
// memory read; the others then read the source tail's link, and a dequeue with more than
// one waiter reads the head's link, a transfer onto a non-empty queue the destination
// tail's link; an enqueue onto a non-empty queue and these last two end with a second
// link write. A finished result waits in an output register without holding up the next
// request's reads, but the next result is not committed, and its writes not done, until
// that register has been taken, so a receiver that holds off stalls the sequencer. After
// reset the block clears the in-queue marks of all waiters before it accepts its first
// transaction.
module linked_list_wait_queues_top #(
  parameter int NUM_QUEUES  = 8,
  parameter int NUM_WAITERS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  llwq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output llwq_pkg::rsp_t  rsp
);
  import llwq_pkg::*;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int WW = $clog2(NUM_WAITERS);
  localparam int LW = $clog2(NUM_WAITERS + 1);
  localparam logic [WW-1:0] LAST_WAITER = WW'(NUM_WAITERS - 1);

  // link memory: {in_queue, next_link}
  logic [WW:0]      wmem [NUM_WAITERS];
  logic [WW:0]      w_rdata;
  logic             w_rd_en, w_we;
  logic [WW-1:0]    w_raddr, w_waddr;
  logic [WW:0]      w_wdata;

  // queue memory: {tail, length}
  logic [WW+LW-1:0] qmem [NUM_QUEUES];
  logic [WW+LW-1:0] q_rdata;
  logic             q_rd_en, q_we;
  logic [QW-1:0]    q_raddr, q_waddr;
  logic [WW+LW-1:0] q_wdata;

  logic [NUM_QUEUES-1:0] qvalid;
  logic             qv_set, qv_clr;
  logic [QW-1:0]    qv_set_idx, qv_clr_idx;

  state_t           state, state_next;
  logic [WW-1:0]    clr_cnt;

  req_t             op;
  logic [WW-1:0]    tail_q, link_w, head, fh, tail_d;
  logic [LW-1:0]    len_q, len_d;
  logic             qv_q, inq_w;
  logic [WW-1:0]    w2_addr, w2_addr_next;
  logic [WW:0]      w2_data, w2_data_next;
  logic             w2_load;

  rsp_t             res;
  logic             fin, commit;

  logic [31:0]      req_q32, req_w32, op_q32, op_d32, op_w32;
  logic [QW-1:0]    req_qi, op_qi, op_di;
  logic [WW-1:0]    req_wi, op_wi;
  logic             q_ok, d_ok, w_ok;
  logic             is_enq, is_deq, is_xfer, is_peek, is_next, bad;
  logic [WW-1:0]    rq_tail, w_link_now;
  logic [LW-1:0]    rq_len_raw, len_now, lend_now;
  logic             qv_now, qd_now, w_inq_now;
  logic             rq_fin, rt_more, move, rd_more;

  assign req_q32 = 32'(req.queue_sel);
  assign req_w32 = 32'(req.waiter_id);
  assign op_q32  = 32'(op.queue_sel);
  assign op_d32  = 32'(op.dest_queue);
  assign op_w32  = 32'(op.waiter_id);
  assign req_qi  = req_q32[QW-1:0];
  assign req_wi  = req_w32[WW-1:0];
  assign op_qi   = op_q32[QW-1:0];
  assign op_di   = op_d32[QW-1:0];
  assign op_wi   = op_w32[WW-1:0];
  assign q_ok    = op_q32 < 32'(NUM_QUEUES);
  assign d_ok    = op_d32 < 32'(NUM_QUEUES);
  assign w_ok    = op_w32 < 32'(NUM_WAITERS);

  assign is_enq  = op.kind == KIND_ENQ;
  assign is_deq  = op.kind == KIND_DEQ;
  assign is_xfer = op.kind == KIND_XFER;
  assign is_peek = op.kind == KIND_PEEK;
  assign is_next = op.kind == KIND_NEXT;
  assign bad     = (op.kind > KIND_NEXT) || !q_ok;

  assign rq_tail    = q_rdata[WW+LW-1:LW];
  assign rq_len_raw = q_rdata[LW-1:0];
  assign w_link_now = w_rdata[WW-1:0];
  assign w_inq_now  = w_rdata[WW];

  // an invalid queue reads as empty
  assign qv_now   = q_ok && qvalid[op_qi];
  assign len_now  = qv_now ? rq_len_raw : '0;
  assign qd_now   = d_ok && qvalid[op_di];
  assign lend_now = qd_now ? rq_len_raw : '0;

  assign rq_fin  = bad
                || (is_enq && (!w_ok || w_inq_now || !qv_now))
                || ((is_deq || is_peek || is_next) && !qv_now)
                || (is_xfer && !d_ok);
  assign rt_more = is_deq && (w_link_now != tail_q);
  assign move    = (op.dest_queue != op.queue_sel) && qv_q;
  assign rd_more = move && qd_now;

  assign fin = ((state == S_RQ) && rq_fin)
            || ((state == S_RT) && !rt_more)
            || (state == S_RH)
            || ((state == S_RD) && !rd_more)
            || (state == S_RT2);
  assign commit = fin && (!rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_cnt == LAST_WAITER) state_next = S_IDLE;
      S_IDLE: if (req_valid) state_next = S_RQ;
      S_RQ: begin
        if (rq_fin) begin
          if (commit) state_next = S_IDLE;
        end else begin
          state_next = is_xfer ? S_RD : S_RT;
        end
      end
      S_RT: begin
        if (rt_more) state_next = S_RH;
        else if (commit) state_next = is_enq ? S_W2 : S_IDLE;
      end
      S_RH:   if (commit) state_next = S_W2;
      S_RD: begin
        if (rd_more) state_next = S_RT2;
        else if (commit) state_next = S_IDLE;
      end
      S_RT2:  if (commit) state_next = S_W2;
      S_W2:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    req_ready    = 1'b0;
    w_rd_en      = 1'b0;
    w_raddr      = '0;
    w_we         = 1'b0;
    w_waddr      = '0;
    w_wdata      = '0;
    q_rd_en      = 1'b0;
    q_raddr      = '0;
    q_we         = 1'b0;
    q_waddr      = '0;
    q_wdata      = '0;
    qv_set       = 1'b0;
    qv_set_idx   = '0;
    qv_clr       = 1'b0;
    qv_clr_idx   = '0;
    w2_load      = 1'b0;
    w2_addr_next = '0;
    w2_data_next = '0;
    res          = '0;
    res.status   = ST_OK;
    unique case (state)
      S_CLR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          q_rd_en = 1'b1;
          q_raddr = req_qi;
          w_rd_en = 1'b1;
          w_raddr = req_wi;
        end
      end
      S_RQ: begin
        if (rq_fin) begin
          priority if (bad) begin
            res.status = ST_NONE;
          end else if (is_enq) begin
            res.length_out = 7'(len_now);
            if (!w_ok) begin
              res.status = ST_NONE;
            end else if (w_inq_now) begin
              res.status = ST_QUEUED;
            end else begin
              // first waiter of an empty queue links to itself
              res.length_out = 7'(LW'(1));
              w_we       = commit;
              w_waddr    = op_wi;
              w_wdata    = {1'b1, op_wi};
              q_we       = commit;
              q_waddr    = op_qi;
              q_wdata    = {op_wi, LW'(1)};
              qv_set     = commit;
              qv_set_idx = op_qi;
            end
          end else if (is_xfer) begin
            res.status = ST_NONE;
          end else begin
            res.status     = ST_NONE;
            res.length_out = 7'(len_now);
          end
        end else begin
          w_rd_en = 1'b1;
          w_raddr = rq_tail;
          if (is_xfer) begin
            q_rd_en = 1'b1;
            q_raddr = op_di;
          end
        end
      end
      S_RT: begin
        // link memory now holds the head of the selected queue
        res.length_out = 7'(len_q);
        if (rt_more) begin
          w_rd_en = 1'b1;
          w_raddr = w_link_now;
        end else if (is_enq) begin
          res.length_out = 7'(len_q + LW'(1));
          w_we         = commit;
          w_waddr      = op_wi;
          w_wdata      = {1'b1, w_link_now};
          w2_load      = commit;
          w2_addr_next = tail_q;
          w2_data_next = {1'b1, op_wi};
          q_we         = commit;
          q_waddr      = op_qi;
          q_wdata      = {op_wi, len_q + LW'(1)};
        end else if (is_deq) begin
          // last waiter leaves
          res.waiter_out   = 6'(w_link_now);
          res.waiter_valid = 1'b1;
          res.length_out   = 7'(len_q - LW'(1));
          w_we       = commit;
          w_waddr    = w_link_now;
          w_wdata    = {1'b0, w_link_now};
          qv_clr     = commit;
          qv_clr_idx = op_qi;
        end else if (is_peek || !op.cursor_valid) begin
          res.waiter_out   = 6'(w_link_now);
          res.waiter_valid = 1'b1;
        end else if (!w_ok || !inq_w || (link_w == w_link_now)) begin
          res.status = ST_NONE;
        end else begin
          res.waiter_out   = 6'(link_w);
          res.waiter_valid = 1'b1;
        end
      end
      S_RH: begin
        res.waiter_out   = 6'(head);
        res.waiter_valid = 1'b1;
        res.length_out   = 7'(len_q - LW'(1));
        w_we         = commit;
        w_waddr      = tail_q;
        w_wdata      = {1'b1, w_link_now};
        w2_load      = commit;
        w2_addr_next = head;
        w2_data_next = {1'b0, head};
        q_we         = commit;
        q_waddr      = op_qi;
        q_wdata      = {tail_q, len_q - LW'(1)};
      end
      S_RD: begin
        if (rd_more) begin
          w_rd_en = 1'b1;
          w_raddr = rq_tail;
        end else if (move) begin
          // destination empty: it takes over the source list as is
          res.length_out = 7'(len_q);
          q_we       = commit;
          q_waddr    = op_di;
          q_wdata    = {tail_q, len_q};
          qv_set     = commit;
          qv_set_idx = op_di;
          qv_clr     = commit;
          qv_clr_idx = op_qi;
        end else begin
          res.length_out = 7'(lend_now);
        end
      end
      S_RT2: begin
        // splice the two rings by swapping the tails' links
        res.length_out = 7'(len_d + len_q);
        w_we         = commit;
        w_waddr      = tail_d;
        w_wdata      = {1'b1, fh};
        w2_load      = commit;
        w2_addr_next = tail_q;
        w2_data_next = {1'b1, w_link_now};
        q_we         = commit;
        q_waddr      = op_di;
        q_wdata      = {tail_q, len_d + len_q};
        qv_set       = commit;
        qv_set_idx   = op_di;
        qv_clr       = commit;
        qv_clr_idx   = op_qi;
      end
      S_W2: begin
        w_we    = 1'b1;
        w_waddr = w2_addr;
        w_wdata = w2_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      qvalid    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_cnt <= clr_cnt + WW'(1);
      if (qv_set) qvalid[qv_set_idx] <= 1'b1;
      if (qv_clr) qvalid[qv_clr_idx] <= 1'b0;
      if (commit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) op <= req;
    if (state == S_RQ) begin
      tail_q <= rq_tail;
      len_q  <= len_now;
      qv_q   <= qv_now;
      inq_w  <= w_inq_now;
      link_w <= w_link_now;
    end
    if (state == S_RT) head <= w_link_now;
    if (state == S_RD) begin
      fh     <= w_link_now;
      tail_d <= rq_tail;
      len_d  <= lend_now;
    end
    if (w2_load) begin
      w2_addr <= w2_addr_next;
      w2_data <= w2_data_next;
    end
    if (commit) rsp <= res;
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (w_rd_en) w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    if (q_rd_en) q_rdata <= qmem[q_raddr];
  end

  a_link_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(w_we && w_rd_en))
    else $error("link memory read and write in the same cycle");

  a_second_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_W2) |-> $past(commit))
    else $error("second link write without a committed result");

  a_valid_conflict: assert property (@(posedge clk) disable iff (rst)
    !(qv_set && qv_clr && (qv_set_idx == qv_clr_idx)))
    else $error("queue valid set and cleared together");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(commit))
    else $error("response raised without a committed transaction");

endmodule
